### rtl/ost_pkg.sv
package ost_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(CAPACITY + 1);

  // fixed field widths of the transactions
  localparam int unsigned OP_FW    = 3;
  localparam int unsigned POS_FW   = 5;
  localparam int unsigned VAL_FW   = 32;
  localparam int unsigned RESP_FW  = 6;
  localparam int unsigned COUNT_FW = 5;

  localparam logic signed [RESP_FW-1:0] NO_POS = '1;

  typedef enum logic [OP_FW-1:0] {
    OP_INS   = 3'd0,
    OP_SINS  = 3'd1,
    OP_ERASE = 3'd2,
    OP_RMV   = 3'd3,
    OP_GET   = 3'd4,
    OP_SET   = 3'd5,
    OP_FIND  = 3'd6,
    OP_RSVD  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_CMP_GE,
    CC_CMP_EQ,
    CC_INS,
    CC_DEL,
    CC_SET
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      at;
    logic      past;
    logic      live;
  } cell_ctl_t;

  typedef struct packed {
    logic [OP_FW-1:0]  op;
    logic [POS_FW-1:0] pos;
    logic [VAL_FW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESP_FW-1:0] position;
    logic                      ok;
    logic [VAL_FW-1:0]         read_value;
    logic [COUNT_FW-1:0]       removed_count;
    logic [COUNT_FW-1:0]       count;
  } out_item_t;

endpackage

### rtl/ost_cell.sv
// one list slot: holds an entry and its match flag, shifts with its neighbors
module ost_cell (
  input  logic                             clk,
  input  ost_pkg::cell_ctl_t               ctl,
  input  logic [ost_pkg::DATA_WIDTH-1:0]   value,
  input  logic [ost_pkg::DATA_WIDTH-1:0]   left_data,
  input  logic [ost_pkg::DATA_WIDTH-1:0]   right_data,
  input  logic                             right_flag,
  input  logic                             hit_in,
  output logic [ost_pkg::DATA_WIDTH-1:0]   data,
  output logic                             flag,
  output logic                             hit_out
);

  logic [ost_pkg::DATA_WIDTH-1:0] data_r;
  logic                           flag_r;

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      ost_pkg::CC_CMP_GE: begin
        flag_r <= ctl.live && !(data_r < value);
      end
      ost_pkg::CC_CMP_EQ: begin
        flag_r <= ctl.live && (data_r == value);
      end
      ost_pkg::CC_INS: begin
        if (ctl.at) begin
          data_r <= value;
        end else if (ctl.past) begin
          data_r <= left_data;
        end
      end
      ost_pkg::CC_DEL: begin
        if (ctl.at || ctl.past) begin
          data_r <= right_data;
          flag_r <= right_flag;
        end
      end
      ost_pkg::CC_SET: begin
        if (ctl.at) begin
          data_r <= value;
        end
      end
      default: begin
      end
    endcase
  end

  assign data    = data_r;
  assign flag    = flag_r;
  // first-hit chain along the row
  assign hit_out = hit_in | flag_r;

endmodule

### rtl/ordered_sequence_table_core.sv
// ordered_sequence_table_core: bounded ordered list held in a row of cells
//
// input channel: in_valid / in_stall / in_data carry one operation per
// transaction (insert at pos, sorted insert, erase, remove all, get, set,
// find). result channel: out_valid / out_stall / out_data carry exactly one
// result per operation, in order.
// an operation is taken only while the core is idle (in_stall low). in the
// accepting cycle every cell compares its entry with the value; then the
// apply step does the shift, load or read and writes the output register,
// waiting while that register is held. remove all deletes one matching
// entry per cycle after the compare, then writes its result.
// the result register is separate from the cells: a finished result may
// wait under out_stall while the next transaction is taken; the core then
// holds in its apply step until the register frees up.
// reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared and are only read below count.
module ordered_sequence_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ost_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ost_pkg::out_item_t out_data
);

  localparam int unsigned CAP = ost_pkg::CAPACITY;
  localparam int unsigned DW  = ost_pkg::DATA_WIDTH;
  localparam int unsigned IW  = ost_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RMV
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ost_pkg::OP_FW-1:0] op_r;
  logic [IW-1:0]             pos_r;
  logic [DW-1:0]             val_r;
  logic [IW-1:0]             cnt_r, cnt_nxt;
  logic [IW-1:0]             rem_r, rem_nxt;
  logic                      out_valid_r;
  ost_pkg::out_item_t        out_data_r;

  // cell row wiring
  ost_pkg::cell_ctl_t  cell_ctl  [CAP];
  logic [DW-1:0]       cell_data [CAP];
  logic                cell_flag [CAP];
  logic [CAP:0]        hit;
  logic [DW-1:0]       cell_value;
  ost_pkg::cell_cmd_t  cell_cmd;
  logic [IW-1:0]       tgt_pos;

  logic [IW-1:0]       p_first;
  logic                any_hit;
  logic [DW-1:0]       rd_data;
  logic                out_free;
  logic                load_out;
  logic                pos_ok;
  logic                room;
  ost_pkg::out_item_t  res;

  assign hit[0]     = 1'b0;
  assign any_hit    = hit[CAP];
  assign cell_value = (state_r == S_IDLE) ? in_data.value[DW-1:0] : val_r;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    logic          right_f;

    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_d = cell_data[i];
      assign right_f = 1'b0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
      assign right_f = cell_flag[i+1];
    end

    assign cell_ctl[i].cmd  = cell_cmd;
    assign cell_ctl[i].at   = (IW'(i) == tgt_pos);
    assign cell_ctl[i].past = (IW'(i) > tgt_pos);
    assign cell_ctl[i].live = (IW'(i) < cnt_r);

    ost_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .value      (cell_value),
      .left_data  (left_d),
      .right_data (right_d),
      .right_flag (right_f),
      .hit_in     (hit[i]),
      .data       (cell_data[i]),
      .flag       (cell_flag[i]),
      .hit_out    (hit[i+1])
    );
  end

  // first flagged cell, or the end of the list when none is flagged
  always_comb begin
    p_first = cnt_r;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (cell_flag[i] && !hit[i]) begin
        p_first = IW'(i);
      end
    end
  end

  // read port: one-hot select by the cell at the target position
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAP; i++) begin
      if (cell_ctl[i].at) begin
        rd_data = cell_data[i];
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign pos_ok   = (pos_r < cnt_r);
  assign room     = (cnt_r < IW'(CAP));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    cell_cmd  = ost_pkg::CC_HOLD;
    tgt_pos   = pos_r;
    load_out  = 1'b0;
    res       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cell_cmd  = (ost_pkg::op_t'(in_data.op) == ost_pkg::OP_SINS) ?
                      ost_pkg::CC_CMP_GE : ost_pkg::CC_CMP_EQ;
          rem_nxt   = '0;
          state_nxt = (ost_pkg::op_t'(in_data.op) == ost_pkg::OP_RMV) ? S_RMV : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          unique case (ost_pkg::op_t'(op_r))
            ost_pkg::OP_INS: begin
              if (room && (pos_r <= cnt_r)) begin
                cell_cmd     = ost_pkg::CC_INS;
                cnt_nxt      = IW'(cnt_r + 1'b1);
                res.position = ost_pkg::RESP_FW'(pos_r);
              end else begin
                res.position = ost_pkg::NO_POS;
              end
            end
            ost_pkg::OP_SINS: begin
              if (room) begin
                cell_cmd     = ost_pkg::CC_INS;
                tgt_pos      = p_first;
                cnt_nxt      = IW'(cnt_r + 1'b1);
                res.position = ost_pkg::RESP_FW'(p_first);
              end else begin
                res.position = ost_pkg::NO_POS;
              end
            end
            ost_pkg::OP_ERASE: begin
              if (pos_ok) begin
                cell_cmd = ost_pkg::CC_DEL;
                cnt_nxt  = IW'(cnt_r - 1'b1);
                res.ok   = 1'b1;
              end
            end
            ost_pkg::OP_RMV: begin
              res.removed_count = ost_pkg::COUNT_FW'(rem_r);
            end
            ost_pkg::OP_GET: begin
              if (pos_ok) begin
                res.ok         = 1'b1;
                res.read_value = ost_pkg::VAL_FW'(rd_data);
              end
            end
            ost_pkg::OP_SET: begin
              if (pos_ok) begin
                cell_cmd = ost_pkg::CC_SET;
                res.ok   = 1'b1;
              end
            end
            ost_pkg::OP_FIND: begin
              res.position = any_hit ? ost_pkg::RESP_FW'(p_first) : ost_pkg::NO_POS;
            end
            ost_pkg::OP_RSVD: begin
              res.position = ost_pkg::NO_POS;
            end
          endcase
        end
      end

      S_RMV: begin
        // drop the first matching entry each cycle, flags shift along
        if (any_hit) begin
          cell_cmd = ost_pkg::CC_DEL;
          tgt_pos  = p_first;
          cnt_nxt  = IW'(cnt_r - 1'b1);
          rem_nxt  = IW'(rem_r + 1'b1);
        end else if (out_free) begin
          load_out          = 1'b1;
          state_nxt         = S_IDLE;
          res.removed_count = ost_pkg::COUNT_FW'(rem_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.count = ost_pkg::COUNT_FW'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation latch and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_data.op;
      pos_r <= IW'(in_data.pos);
      val_r <= in_data.value[DW-1:0];
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IW'(CAP))
    else $error("entry count above capacity");

  a_rmv_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMV && any_hit) |=> (cnt_r == IW'($past(cnt_r) - 1'b1)))
    else $error("remove step did not drop one entry");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (state_r != S_IDLE))
    else $error("result written with no operation in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted transaction left core idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result register overwritten while held");

endmodule
